// ===== hw/rtl/rcst_pkg.sv =====
// Shared types, sizes and codes for the refcounted session slot table.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package rcst_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int PIN_BITS   = 16;
	localparam int ID_W       = 31;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [PIN_BITS-1:0] pin_t;
	typedef logic [ID_W-1:0]     sid_t;

	localparam cnt_t  CNT_FULL  = cnt_t'(SLOT_COUNT);
	localparam slot_t SLOT_LAST = slot_t'(SLOT_COUNT - 1);
	localparam pin_t  PIN_MAX   = '1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_UNUSED   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_BUMP,
		S_POP,
		S_CLAIM,
		S_REL_RD,
		S_REL_CHK,
		S_DONE
	} state_t;

	// Commands from the sequencer to the slot store
	typedef struct packed {
		logic  rd_en;
		slot_t rd_addr;
		slot_t wr_addr;
		logic  id_we;
		sid_t  id_wdata;
		logic  pin_we;
		pin_t  pin_wdata;
		logic  set_valid;
		logic  clr_valid;
	} store_cmd_t;

	// Registered read of one slot, compared against the lookup key
	typedef struct packed {
		logic valid;
		logic hit;
		pin_t pins;
	} store_rsp_t;

	typedef struct packed {
		logic  pop;
		logic  push;
		slot_t push_slot;
	} fs_cmd_t;

	typedef struct packed {
		slot_t top_slot;
		cnt_t  depth;
	} fs_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcst_if.sv =====
// Valid/ready channel interfaces for the request and result words.
// Depends on rcst_pkg for payload types.
`default_nettype none

interface rcst_req_if;
	logic                valid;
	logic                ready;
	logic                mode;
	rcst_pkg::sid_t      session_id;
	rcst_pkg::slot_t     slot;

	modport source (output valid, output mode, output session_id, output slot, input ready);
	modport sink   (input valid, input mode, input session_id, input slot, output ready);
endinterface

interface rcst_rsp_if;
	logic                 valid;
	logic                 ready;
	rcst_pkg::slot_t      slot_index;
	rcst_pkg::pin_t       pin_count;
	rcst_pkg::status_t    status;
	logic                 newly_taken;
	logic                 freed;
	rcst_pkg::cnt_t       slots_in_use;

	modport source (output valid, output slot_index, output pin_count, output status,
		output newly_taken, output freed, output slots_in_use, input ready);
	modport sink   (input valid, input slot_index, input pin_count, input status,
		input newly_taken, input freed, input slots_in_use, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/refcounted_session_slot_table.sv =====
// Refcounted session slot table: top level with the request sequencer.
// Depends on rcst_pkg, rcst_if, rcst_slot_store and rcst_free_stack.
//
// Usage: requests arrive as words on req (valid/ready); mode 0 acquires a slot
// for session_id, mode 1 releases one pin of slot. Each request gives exactly
// one result word on rsp (valid/ready): slot index, pin count after the
// request, status, taken/freed flags and the number of slots in use.
// Timing: the block takes one request at a time. An acquire scans the
// identifier memory one slot per cycle through its single read port, so an
// acquire that matches slot k finishes once slot k has been read, while one
// that claims a free slot or finds the table full reads every slot first.
// A release reads its slot, then writes it. req.ready returns as the result
// word is loaded into the output register. The slot scan is the limit on
// throughput.
// Reset: all slots free and unpinned, free stack holds every slot with slot 0
// on top, no clearing pass is needed; requests are taken straight away.
// Stall: the result sits in an output register; req.ready returns while that
// word is still waiting, and a finished second result holds until rsp.ready.
`default_nettype none

module refcounted_session_slot_table (
	input  wire        clk,
	input  wire        arst_n,
	rcst_req_if.sink   req,
	rcst_rsp_if.source rsp
);

	typedef struct packed {
		rcst_pkg::slot_t   slot_index;
		rcst_pkg::pin_t    pin_count;
		rcst_pkg::status_t status;
		logic              newly_taken;
		logic              freed;
		rcst_pkg::cnt_t    slots_in_use;
	} res_t;

	rcst_pkg::state_t     state_q, state_d;
	rcst_pkg::sid_t       sid_q;
	rcst_pkg::slot_t      slot_q;
	rcst_pkg::cnt_t       scan_q, scan_d;
	logic                 chk_q, chk_d;
	rcst_pkg::slot_t      chk_idx_q, chk_idx_d;
	rcst_pkg::cnt_t       used_q, used_d;
	res_t                 res_q, res_d;
	res_t                 out_q;
	logic                 out_valid_q;
	logic                 res_load;
	logic                 in_fire;
	logic                 out_fire;
	rcst_pkg::pin_t       rel_pins;
	rcst_pkg::store_cmd_t st_cmd;
	rcst_pkg::store_rsp_t st_rsp;
	rcst_pkg::fs_cmd_t    fs_cmd;
	rcst_pkg::fs_rsp_t    fs_rsp;

	rcst_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (st_cmd),
		.key    (sid_q),
		.rsp    (st_rsp)
	);

	rcst_free_stack u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fs_cmd),
		.rsp    (fs_rsp)
	);

	assign req.ready = (state_q == rcst_pkg::S_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_fire  = out_valid_q && rsp.ready;
	assign rel_pins  = (st_rsp.pins != '0) ? st_rsp.pins - rcst_pkg::pin_t'(1) : '0;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rcst_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and unit commands
	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		chk_d     = chk_q;
		chk_idx_d = chk_idx_q;
		used_d    = used_q;
		res_load  = 1'b0;
		res_d     = res_q;
		st_cmd    = '0;
		fs_cmd    = '0;
		unique case (state_q)
			rcst_pkg::S_IDLE: begin
				if (in_fire) begin
					scan_d  = '0;
					chk_d   = 1'b0;
					state_d = req.mode ? rcst_pkg::S_REL_RD : rcst_pkg::S_SCAN;
				end
			end
			rcst_pkg::S_SCAN: begin
				// check the previous read, issue the next one
				if (chk_q && st_rsp.hit) begin
					state_d = rcst_pkg::S_BUMP;
				end else if (chk_q && chk_idx_q == rcst_pkg::SLOT_LAST) begin
					state_d = rcst_pkg::S_POP;
				end else begin
					chk_d = 1'b0;
					if (scan_q < rcst_pkg::CNT_FULL) begin
						st_cmd.rd_en   = 1'b1;
						st_cmd.rd_addr = scan_q[rcst_pkg::SLOT_W-1:0];
						chk_idx_d      = scan_q[rcst_pkg::SLOT_W-1:0];
						chk_d          = 1'b1;
						scan_d         = scan_q + rcst_pkg::cnt_t'(1);
					end
				end
			end
			rcst_pkg::S_BUMP: begin
				res_load          = 1'b1;
				res_d             = '0;
				res_d.slot_index  = chk_idx_q;
				if (st_rsp.pins == rcst_pkg::PIN_MAX) begin
					res_d.pin_count = st_rsp.pins;
					res_d.status    = rcst_pkg::ST_OVERFLOW;
				end else begin
					st_cmd.pin_we    = 1'b1;
					st_cmd.wr_addr   = chk_idx_q;
					st_cmd.pin_wdata = st_rsp.pins + rcst_pkg::pin_t'(1);
					res_d.pin_count  = st_rsp.pins + rcst_pkg::pin_t'(1);
					res_d.status     = rcst_pkg::ST_OK;
				end
				state_d = rcst_pkg::S_DONE;
			end
			rcst_pkg::S_POP: begin
				if (fs_rsp.depth == '0) begin
					res_load     = 1'b1;
					res_d        = '0;
					res_d.status = rcst_pkg::ST_FULL;
					state_d      = rcst_pkg::S_DONE;
				end else begin
					fs_cmd.pop = 1'b1;
					state_d    = rcst_pkg::S_CLAIM;
				end
			end
			rcst_pkg::S_CLAIM: begin
				st_cmd.wr_addr    = fs_rsp.top_slot;
				st_cmd.id_we      = 1'b1;
				st_cmd.id_wdata   = sid_q;
				st_cmd.pin_we     = 1'b1;
				st_cmd.pin_wdata  = rcst_pkg::pin_t'(1);
				st_cmd.set_valid  = 1'b1;
				used_d            = used_q + rcst_pkg::cnt_t'(1);
				res_load          = 1'b1;
				res_d             = '0;
				res_d.slot_index  = fs_rsp.top_slot;
				res_d.pin_count   = rcst_pkg::pin_t'(1);
				res_d.status      = rcst_pkg::ST_OK;
				res_d.newly_taken = 1'b1;
				state_d           = rcst_pkg::S_DONE;
			end
			rcst_pkg::S_REL_RD: begin
				st_cmd.rd_en   = 1'b1;
				st_cmd.rd_addr = slot_q;
				state_d        = rcst_pkg::S_REL_CHK;
			end
			rcst_pkg::S_REL_CHK: begin
				res_load         = 1'b1;
				res_d            = '0;
				res_d.slot_index = slot_q;
				st_cmd.wr_addr   = slot_q;
				if (!st_rsp.valid) begin
					res_d.status = rcst_pkg::ST_UNUSED;
				end else if (rel_pins == '0) begin
					// last pin gone: drop the slot and return it to the stack
					st_cmd.pin_we    = 1'b1;
					st_cmd.pin_wdata = '0;
					st_cmd.clr_valid = 1'b1;
					fs_cmd.push      = 1'b1;
					fs_cmd.push_slot = slot_q;
					if (used_q != '0)
						used_d = used_q - rcst_pkg::cnt_t'(1);
					res_d.status = rcst_pkg::ST_OK;
					res_d.freed  = 1'b1;
				end else begin
					st_cmd.pin_we    = 1'b1;
					st_cmd.pin_wdata = rel_pins;
					res_d.pin_count  = rel_pins;
					res_d.status     = rcst_pkg::ST_OK;
				end
				state_d = rcst_pkg::S_DONE;
			end
			rcst_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready)
					state_d = rcst_pkg::S_IDLE;
			end
			default: state_d = rcst_pkg::S_IDLE;
		endcase
		if (res_load)
			res_d.slots_in_use = used_d;
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			chk_q     <= 1'b0;
			chk_idx_q <= '0;
			used_q    <= '0;
		end else begin
			scan_q    <= scan_d;
			chk_q     <= chk_d;
			chk_idx_q <= chk_idx_d;
			used_q    <= used_d;
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sid_q  <= req.session_id;
			slot_q <= req.slot;
		end
		if (res_load)
			res_q <= res_d;
		if (state_q == rcst_pkg::S_DONE && (!out_valid_q || rsp.ready))
			out_q <= res_q;
	end

	// Output register: load the finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == rcst_pkg::S_DONE && (!out_valid_q || rsp.ready))
			out_valid_q <= 1'b1;
		else if (out_fire)
			out_valid_q <= 1'b0;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.slot_index   = out_q.slot_index;
	assign rsp.pin_count    = out_q.pin_count;
	assign rsp.status       = out_q.status;
	assign rsp.newly_taken  = out_q.newly_taken;
	assign rsp.freed        = out_q.freed;
	assign rsp.slots_in_use = out_q.slots_in_use;

	// Slots in use and free slots add up to the table size, except while a
	// popped slot waits in S_CLAIM to be claimed
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rcst_pkg::S_CLAIM) |->
		(({1'b0, used_q} + {1'b0, fs_rsp.depth}) ==
			(rcst_pkg::CNT_W + 1)'(rcst_pkg::SLOT_COUNT)))
		else $error("slot accounting out of balance");

	// A newly taken slot starts with one pin
	a_taken_one_pin: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.newly_taken) |->
		(rsp.pin_count == rcst_pkg::pin_t'(1) && rsp.status == rcst_pkg::ST_OK))
		else $error("taken slot without exactly one pin");

	// A freed slot reports no pins left
	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.freed) |-> (rsp.pin_count == '0 && !rsp.newly_taken))
		else $error("freed slot still pinned");

	// The pin update only runs on a slot the scan actually matched
	a_bump_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcst_pkg::S_BUMP) |-> st_rsp.hit)
		else $error("pin update without a matching slot");

	// An accepted request always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != rcst_pkg::S_IDLE))
		else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

// ===== hw/rtl/rcst_slot_store.sv =====
// Slot store: owner identifier memory, pin count memory, valid flags and the
// shared identifier comparator. Depends on rcst_pkg.
`default_nettype none

module rcst_slot_store (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rcst_pkg::store_cmd_t cmd,
	input  rcst_pkg::sid_t       key,
	output rcst_pkg::store_rsp_t rsp
);

	rcst_pkg::sid_t                 id_mem  [rcst_pkg::SLOT_COUNT];
	rcst_pkg::pin_t                 pin_mem [rcst_pkg::SLOT_COUNT];
	logic [rcst_pkg::SLOT_COUNT-1:0] valid_q;
	rcst_pkg::sid_t                 id_rd_q;
	rcst_pkg::pin_t                 pin_rd_q;
	logic                           vld_rd_q;

	// Identifier memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.id_we)
			id_mem[cmd.wr_addr] <= cmd.id_wdata;
		if (cmd.rd_en)
			id_rd_q <= id_mem[cmd.rd_addr];
	end

	// Pin count memory, same addressing
	always_ff @(posedge clk) begin
		if (cmd.pin_we)
			pin_mem[cmd.wr_addr] <= cmd.pin_wdata;
		if (cmd.rd_en)
			pin_rd_q <= pin_mem[cmd.rd_addr];
	end

	// Valid flags, cleared at reset; hold the read flag between reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.set_valid)
				valid_q[cmd.wr_addr] <= 1'b1;
			else if (cmd.clr_valid)
				valid_q[cmd.wr_addr] <= 1'b0;
			if (cmd.rd_en)
				vld_rd_q <= valid_q[cmd.rd_addr];
		end
	end

	// Compare the slot just read against the key
	assign rsp.valid = vld_rd_q;
	assign rsp.hit   = vld_rd_q && (id_rd_q == key);
	assign rsp.pins  = pin_rd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rcst_free_stack.sv =====
// Free slot stack with a low-water mark standing in for the reset contents.
// Depends on rcst_pkg.
`default_nettype none

module rcst_free_stack (
	input  wire               clk,
	input  wire               arst_n,
	input  rcst_pkg::fs_cmd_t cmd,
	output rcst_pkg::fs_rsp_t rsp
);

	rcst_pkg::slot_t stk_mem [rcst_pkg::SLOT_COUNT];
	rcst_pkg::cnt_t  depth_q;
	rcst_pkg::cnt_t  low_q;
	rcst_pkg::cnt_t  rd_pos_ext;
	rcst_pkg::slot_t rd_pos;
	rcst_pkg::slot_t wr_pos;
	rcst_pkg::slot_t mem_rd_q;
	rcst_pkg::slot_t init_rd_q;
	logic            init_sel_q;
	logic            push_ok;

	assign rd_pos_ext = depth_q - rcst_pkg::cnt_t'(1);
	assign rd_pos     = rd_pos_ext[rcst_pkg::SLOT_W-1:0];
	assign wr_pos     = depth_q[rcst_pkg::SLOT_W-1:0];
	assign push_ok    = cmd.push && (depth_q < rcst_pkg::CNT_FULL);

	// Stack memory; positions below the low-water mark were never written
	// and still read as their reset value, last slot at the bottom
	always_ff @(posedge clk) begin
		if (push_ok)
			stk_mem[wr_pos] <= cmd.push_slot;
		if (cmd.pop) begin
			mem_rd_q  <= stk_mem[rd_pos];
			init_rd_q <= rcst_pkg::SLOT_LAST - rd_pos;
		end
	end

	// Depth and low-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= rcst_pkg::CNT_FULL;
			low_q      <= rcst_pkg::CNT_FULL;
			init_sel_q <= 1'b0;
		end else if (cmd.pop) begin
			depth_q    <= rd_pos_ext;
			init_sel_q <= (rd_pos_ext < low_q);
			if (rd_pos_ext < low_q)
				low_q <= rd_pos_ext;
		end else if (push_ok) begin
			depth_q <= depth_q + rcst_pkg::cnt_t'(1);
		end
	end

	assign rsp.top_slot = init_sel_q ? init_rd_q : mem_rd_q;
	assign rsp.depth    = depth_q;

endmodule

`default_nettype wire
